### rtl/core/kcf_pkg.sv
// Package for the keyword content filter: item types, keyword table,
// content-type header text and sizing constants. No dependencies.
`timescale 1ns / 1ps

package kcf_pkg;

    localparam int MAX_KEYWORD_LEN = 14;
    localparam int KEYWORD_COUNT   = 9;
    localparam int KW_ROW          = 32;
    localparam int HEAD_LEN        = 18;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [4:0] LINE_POS_MAX = 5'd31;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic keyword_found;
        logic text_type_seen;
        logic block_chunk;
    } t_out_item;

    // Byte as classified by the front end and carried through the queue.
    typedef struct packed {
        logic [7:0] raw_byte;
        logic [7:0] folded_byte;
        logic       newline;
        logic       last_byte;
    } t_q_item;

    // Header bytes that a text content-type line must start with.
    localparam logic [7:0] HEAD_UPPER [HEAD_LEN] = '{
        "C", "o", "n", "t", "e", "n", "t", "-", "T", "y", "p", "e", ":", " ",
        "t", "e", "x", "t"
    };
    localparam logic [7:0] HEAD_LOWER [HEAD_LEN] = '{
        "c", "o", "n", "t", "e", "n", "t", "-", "t", "y", "p", "e", ":", " ",
        "t", "e", "x", "t"
    };

    // Keyword text, right aligned: the first character sits in the highest
    // used byte of the row.
    function automatic logic [KW_ROW*8-1:0] kw_row(input int k);
        logic [KW_ROW*8-1:0] row;
        row = '0;
        case (k)
            0: row = (KW_ROW*8)'({8'h6e, 8'h6f, 8'h72, 8'h72, 8'h6b, 8'hc3, 8'hb6,
                                  8'h70, 8'h69, 8'h6e, 8'h67});
            1: row = "spongebob";
            2: row = "norrkoping";
            3: row = "paris hilton";
            4: row = "britney spears";
            5: row = "parishilton";
            6: row = "britneyspears";
            7: row = "britney+spears";
            8: row = "paris+hilton";
            default: row = '0;
        endcase
        return row;
    endfunction

    function automatic int kw_len(input int k);
        int len;
        len = 0;
        case (k)
            0: len = 11;
            1: len = 9;
            2: len = 10;
            3: len = 12;
            4: len = 14;
            5: len = 11;
            6: len = 13;
            7: len = 14;
            8: len = 12;
            default: len = 0;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/kcf_front.sv
// Front end of the keyword content filter: input register, case folding
// and newline classification. Depends on kcf_pkg.
`timescale 1ns / 1ps

module kcf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  kcf_pkg::t_in_item i_in_data,
    input  logic              i_q_full,
    output logic              o_q_push,
    output kcf_pkg::t_q_item  o_q_data
);

    logic             r_valid;
    logic             n_valid;
    kcf_pkg::t_q_item r_item;
    kcf_pkg::t_q_item n_item;
    logic             accept;
    logic [7:0]       b;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = r_valid && !i_q_full;
    assign o_q_data   = r_item;
    assign b          = i_in_data.data_byte;

    always_comb begin
        n_item.raw_byte    = b;
        n_item.folded_byte = (b >= kcf_pkg::CHAR_UPPER_A && b <= kcf_pkg::CHAR_UPPER_Z)
                             ? b + kcf_pkg::CASE_OFFSET : b;
        n_item.newline     = (b == kcf_pkg::CHAR_NEWLINE);
        n_item.last_byte   = i_in_data.last_byte;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_q_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

### rtl/core/kcf_queue.sv
// Short queue of classified bytes between the front and back ends of the
// keyword content filter. Depends on kcf_pkg.
`timescale 1ns / 1ps

module kcf_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kcf_pkg::t_q_item i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output kcf_pkg::t_q_item o_data
);

    kcf_pkg::t_q_item                 r_mem [kcf_pkg::QUEUE_DEPTH];
    logic [kcf_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [kcf_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [kcf_pkg::QUEUE_AW:0]       r_count;
    logic [kcf_pkg::QUEUE_AW:0]       n_count;

    assign o_full  = (r_count == (kcf_pkg::QUEUE_AW+1)'(kcf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### rtl/core/kcf_back.sv
// Back end of the keyword content filter: match window, keyword comparators,
// line-start header tracker and result register. Depends on kcf_pkg.
`timescale 1ns / 1ps

module kcf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_require_text,
    input  logic               i_q_valid,
    input  kcf_pkg::t_q_item   i_q_data,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kcf_pkg::t_out_item o_out_data
);

    localparam int ML = kcf_pkg::MAX_KEYWORD_LEN;

    logic [7:0]         r_recent [ML-1];
    logic [7:0]         win [ML];
    logic               r_hit;
    logic [4:0]         r_pos;
    logic               r_up_ok;
    logic               r_lo_ok;
    logic               r_text;
    logic               n_hit;
    logic [4:0]         n_pos;
    logic               n_up_ok;
    logic               n_lo_ok;
    logic               n_text;
    logic               r_out_valid;
    kcf_pkg::t_out_item r_out_data;
    logic [kcf_pkg::KEYWORD_COUNT-1:0] kw_match;
    logic               out_free;
    logic               is_last;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_last     = i_q_data.last_byte;
    assign o_q_pop     = i_q_valid && (!is_last || out_free);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        for (int i = 0; i < ML - 1; i++) begin
            win[i] = r_recent[i];
        end
        win[ML-1] = i_q_data.folded_byte;
    end

    // One comparator row per keyword, aligned so the keyword ends at the
    // newest byte of the window.
    for (genvar gk = 0; gk < kcf_pkg::KEYWORD_COUNT; gk++) begin : g_kw
        localparam int L = kcf_pkg::kw_len(gk);
        localparam logic [kcf_pkg::KW_ROW*8-1:0] ROW = kcf_pkg::kw_row(gk);
        if (L != 0 && L <= ML && L <= kcf_pkg::KW_ROW) begin : g_used
            logic [L-1:0] eq;
            for (genvar gi = 0; gi < L; gi++) begin : g_pos
                assign eq[gi] = (win[ML-L+gi] == ROW[(L-1-gi)*8 +: 8]);
            end
            assign kw_match[gk] = &eq;
        end else begin : g_unused
            assign kw_match[gk] = 1'b0;
        end
    end

    always_comb begin
        n_hit   = r_hit || (|kw_match);
        n_pos   = r_pos;
        n_up_ok = r_up_ok;
        n_lo_ok = r_lo_ok;
        n_text  = r_text;
        if (i_q_data.newline) begin
            n_pos   = '0;
            n_up_ok = 1'b1;
            n_lo_ok = 1'b1;
        end else begin
            if (r_pos < 5'(kcf_pkg::HEAD_LEN)) begin
                n_up_ok = r_up_ok && (i_q_data.raw_byte == kcf_pkg::HEAD_UPPER[r_pos]);
                n_lo_ok = r_lo_ok && (i_q_data.raw_byte == kcf_pkg::HEAD_LOWER[r_pos]);
                if (r_pos == 5'(kcf_pkg::HEAD_LEN - 1) && (n_up_ok || n_lo_ok)) begin
                    n_text = 1'b1;
                end
            end
            if (r_pos < kcf_pkg::LINE_POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ML - 1; i++) begin
                r_recent[i] <= '0;
            end
            r_hit       <= 1'b0;
            r_pos       <= '0;
            r_up_ok     <= 1'b1;
            r_lo_ok     <= 1'b1;
            r_text      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop && is_last) begin
                for (int i = 0; i < ML - 1; i++) begin
                    r_recent[i] <= '0;
                end
                r_hit       <= 1'b0;
                r_pos       <= '0;
                r_up_ok     <= 1'b1;
                r_lo_ok     <= 1'b1;
                r_text      <= 1'b0;
                r_out_valid <= 1'b1;
            end else begin
                if (o_q_pop) begin
                    for (int i = 0; i < ML - 1; i++) begin
                        r_recent[i] <= win[i+1];
                    end
                    r_hit   <= n_hit;
                    r_pos   <= n_pos;
                    r_up_ok <= n_up_ok;
                    r_lo_ok <= n_lo_ok;
                    r_text  <= n_text;
                end
                if (r_out_valid && !i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
        if (o_q_pop && is_last) begin
            r_out_data.keyword_found  <= n_hit;
            r_out_data.text_type_seen <= n_text;
            r_out_data.block_chunk    <= n_hit && (!i_require_text || n_text);
        end
    end

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && is_last) |=> o_out_valid)
        else $error("result not presented after last byte");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && is_last) |=> (!r_hit && !r_text && r_pos == '0 && r_up_ok && r_lo_ok))
        else $error("chunk state not cleared after last byte");

    a_block_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.block_chunk || o_out_data.keyword_found))
        else $error("block asserted without keyword");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("pending result overwritten");

endmodule

### rtl/core/keyword_content_filter.sv
// Top level of the keyword content filter: configuration register and the
// front end, queue and back end. Depends on kcf_pkg, kcf_front, kcf_queue, kcf_back.
`timescale 1ns / 1ps

// The filter takes one byte of a message chunk per transaction, with a flag
// on the final byte, and returns one result transaction per chunk when that
// final byte has been processed. A keyword hit is sticky for the chunk and is
// found case-insensitively (ASCII A-Z only) among nine fixed keywords, one of
// them in UTF-8; a line that starts with "Content-Type: text" or
// "content-type: text" marks the chunk as text. The block decision is the
// keyword hit, also gated on the text mark when the configuration bit is set;
// write that bit only while no chunk is in flight. Throughput is one byte per
// clock: the back end consumes one queued byte each cycle, with all keyword
// comparators working in parallel on a 14-byte window, but holds a final byte
// while a result waits at a stalled output. A byte passes the input register,
// the four-entry queue and the back end, whose result register presents the
// chunk's result. Input stall rises only when the queue is full, which happens
// only while a result waits at a stalled output.
module keyword_content_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kcf_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kcf_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    // Configuration: the register always takes a write transaction.
    logic r_require_text;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_text <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_require_text <= i_cfg_data;
        end
    end

    logic             q_full;
    logic             q_push;
    kcf_pkg::t_q_item q_push_data;
    logic             q_pop;
    logic             q_valid;
    kcf_pkg::t_q_item q_data;

    // Front end registers and classifies each incoming byte.
    kcf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_push_data)
    );

    // The queue lets the front keep taking bytes while a result is held.
    kcf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_data      (q_data)
    );

    // Back end does the matching and owns the result register.
    kcf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_require_text (r_require_text),
        .i_q_valid      (q_valid),
        .i_q_data       (q_data),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
